// ----- rtl/bgd_pkg.sv -----
// Shared types and constants for the button gesture detector.
package bgd_pkg;

  // Gesture codes reported on the result channel
  localparam logic [2:0] GEST_POSITION  = 3'd0;
  localparam logic [2:0] GEST_INITIAL   = 3'd1;
  localparam logic [2:0] GEST_SHORT_REL = 3'd2;
  localparam logic [2:0] GEST_LONG      = 3'd3;
  localparam logic [2:0] GEST_LONG_REL  = 3'd4;
  localparam logic [2:0] GEST_ONGOING   = 3'd5;
  localparam logic [2:0] GEST_COMPLETE  = 3'd6;

  // Input operation codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_LONG_PRESS_TICKS  = 2'd0;
  localparam logic [1:0] CFG_MULTI_PRESS_TICKS = 2'd1;
  localparam logic [1:0] CFG_PRESS_LIMIT       = 2'd2;

  localparam logic [15:0] LONG_PRESS_TICKS_RST  = 16'd800;
  localparam logic [15:0] MULTI_PRESS_TICKS_RST = 16'd350;
  localparam logic [3:0]  PRESS_LIMIT_RST       = 4'd2;

  // Event queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef struct packed {
    logic op;
    logic pressed;
  } in_t;

  typedef struct packed {
    logic       position;
    logic [2:0] gesture;
    logic [4:0] press_count;
    logic       last_of_run;
  } out_t;

  // All results caused by one input item; r0 always valid, r1 when two is set
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } ev_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ----- rtl/button_gesture_detector_core.sv -----
// Top level of the button gesture detector.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------------------
//  in       | in_valid / in_ready      | in_data  : op, pressed
//  out      | out_valid / out_ready    | out_data : position, gesture, press_count,
//           |                          |            last_of_run
//  cfg      | cfg_we (no wait)         | cfg_index, cfg_data
//
// One input item is taken per cycle while the event queue has room; its state
// update and classification finish in that cycle and the results go into a
// four-entry event queue. The output side delivers one result per cycle while
// out_ready is high, so items with two results let the output port set the rate.
// in_ready drops only while the event queue is full. Synchronous reset restores
// the register defaults and clears all gesture state; no clearing pass is needed.
module button_gesture_detector_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  bgd_pkg::in_t   in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bgd_pkg::out_t  out_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  bgd_pkg::ev_t     q_wr;
  bgd_pkg::ev_t     q_rd;
  bgd_pkg::q_stat_t q_stat;
  logic             q_push;
  logic             q_pop;
  logic             acc;

  assign in_ready = !q_stat.full;
  assign acc      = in_valid && in_ready;

  bgd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .acc       (acc),
    .item      (in_data),
    .push      (q_push),
    .ev        (q_wr)
  );

  bgd_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wr),
    .pop   (q_pop),
    .rdata (q_rd),
    .stat  (q_stat)
  );

  bgd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rd      (q_rd),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  a_pop_not_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_stat.empty)
    else $error("event queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_stat.full)
    else $error("event queue pushed while full");

  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_data.last_of_run |=> out_valid)
    else $error("second result of an item not presented straight after the first");

  a_count_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.gesture != bgd_pkg::GEST_ONGOING &&
    out_data.gesture != bgd_pkg::GEST_COMPLETE |-> out_data.press_count == 5'd0)
    else $error("press count reported with a gesture that carries none");
`endif

endmodule

// ----- rtl/bgd_front.sv -----
// Front end: configuration, gesture state, timers and result classification.
module bgd_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  input  logic            acc,
  input  bgd_pkg::in_t    item,
  output logic            push,
  output bgd_pkg::ev_t    ev
);

  logic [15:0] long_press_ticks;
  logic [15:0] multi_press_ticks;
  logic [3:0]  press_limit;

  logic        synced, synced_next;
  logic        level_seen, level_seen_next;
  logic        press_active, press_active_next;
  logic        long_reported, long_reported_next;
  logic [4:0]  presses, presses_next;
  logic [15:0] hold_timer, hold_timer_next;
  logic        hold_armed, hold_armed_next;
  logic [15:0] gap_timer, gap_timer_next;
  logic        gap_armed, gap_armed_next;

  bgd_pkg::out_t ra, rb;
  logic          ra_v, rb_v;
  logic [4:0]    pn;
  logic [4:0]    sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ticks  <= bgd_pkg::LONG_PRESS_TICKS_RST;
      multi_press_ticks <= bgd_pkg::MULTI_PRESS_TICKS_RST;
      press_limit       <= bgd_pkg::PRESS_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bgd_pkg::CFG_LONG_PRESS_TICKS:  long_press_ticks  <= cfg_data;
        bgd_pkg::CFG_MULTI_PRESS_TICKS: multi_press_ticks <= cfg_data;
        bgd_pkg::CFG_PRESS_LIMIT:       press_limit       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign sat = {1'b0, press_limit} + 5'd1;

  always_comb begin
    synced_next        = synced;
    level_seen_next    = level_seen;
    press_active_next  = press_active;
    long_reported_next = long_reported;
    presses_next       = presses;
    hold_timer_next    = hold_timer;
    hold_armed_next    = hold_armed;
    gap_timer_next     = gap_timer;
    gap_armed_next     = gap_armed;
    ra   = '0;
    rb   = '0;
    ra_v = 1'b0;
    rb_v = 1'b0;
    pn   = (presses < sat) ? presses + 5'd1 : presses;

    if (item.op == bgd_pkg::OP_TICK) begin
      if (hold_armed) begin
        if (hold_timer <= 16'd1) begin
          hold_timer_next = '0;
          hold_armed_next = 1'b0;
          if (press_active && level_seen) begin
            long_reported_next = 1'b1;
            ra_v        = 1'b1;
            ra.position = 1'b1;
            ra.gesture  = bgd_pkg::GEST_LONG;
          end
        end else begin
          hold_timer_next = hold_timer - 16'd1;
        end
      end
      if (gap_armed) begin
        if (gap_timer <= 16'd1) begin
          gap_timer_next = '0;
          gap_armed_next = 1'b0;
          presses_next   = '0;
          rb_v           = 1'b1;
          rb.gesture     = bgd_pkg::GEST_COMPLETE;
          rb.press_count = (presses <= {1'b0, press_limit}) ? presses : 5'd0;
        end else begin
          gap_timer_next = gap_timer - 16'd1;
        end
      end
    end else if (!synced) begin
      synced_next     = 1'b1;
      level_seen_next = item.pressed;
      ra_v            = 1'b1;
      ra.position     = item.pressed;
      ra.gesture      = bgd_pkg::GEST_POSITION;
    end else if (level_seen != item.pressed) begin
      level_seen_next = item.pressed;
      if (item.pressed) begin
        gap_armed_next     = 1'b0;
        gap_timer_next     = '0;
        press_active_next  = 1'b1;
        long_reported_next = 1'b0;
        presses_next       = pn;
        ra_v        = 1'b1;
        ra.position = 1'b1;
        ra.gesture  = bgd_pkg::GEST_INITIAL;
        if (pn > 5'd1) begin
          rb_v           = 1'b1;
          rb.position    = 1'b1;
          rb.gesture     = bgd_pkg::GEST_ONGOING;
          rb.press_count = pn;
        end else begin
          hold_timer_next = long_press_ticks;
          hold_armed_next = 1'b1;
        end
      end else begin
        hold_armed_next = 1'b0;
        hold_timer_next = '0;
        ra_v            = 1'b1;
        if (!press_active) begin
          ra.gesture = bgd_pkg::GEST_POSITION;
        end else begin
          press_active_next = 1'b0;
          ra.gesture = long_reported ? bgd_pkg::GEST_LONG_REL : bgd_pkg::GEST_SHORT_REL;
          if (long_reported) begin
            presses_next = '0;
          end else begin
            gap_timer_next = multi_press_ticks;
            gap_armed_next = 1'b1;
          end
        end
      end
    end
  end

  // pack the results of this item; hold result ahead of gap result
  always_comb begin
    ev = '0;
    if (ra_v) begin
      ev.r0  = ra;
      ev.r1  = rb;
      ev.two = rb_v;
    end else begin
      ev.r0  = rb;
    end
    ev.r0.last_of_run = !ev.two;
    ev.r1.last_of_run = 1'b1;
  end

  assign push = acc && (ra_v || rb_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      synced        <= 1'b0;
      level_seen    <= 1'b0;
      press_active  <= 1'b0;
      long_reported <= 1'b0;
      presses       <= '0;
      hold_timer    <= '0;
      hold_armed    <= 1'b0;
      gap_timer     <= '0;
      gap_armed     <= 1'b0;
    end else if (acc) begin
      synced        <= synced_next;
      level_seen    <= level_seen_next;
      press_active  <= press_active_next;
      long_reported <= long_reported_next;
      presses       <= presses_next;
      hold_timer    <= hold_timer_next;
      hold_armed    <= hold_armed_next;
      gap_timer     <= gap_timer_next;
      gap_armed     <= gap_armed_next;
    end
  end

endmodule

// ----- rtl/bgd_queue.sv -----
// Small event queue between the front and back ends.
module bgd_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  bgd_pkg::ev_t      wdata,
  input  logic              pop,
  output bgd_pkg::ev_t      rdata,
  output bgd_pkg::q_stat_t  stat
);

  bgd_pkg::ev_t            mem [bgd_pkg::QDEPTH];
  logic [bgd_pkg::QAW-1:0] wptr;
  logic [bgd_pkg::QAW-1:0] rptr;
  logic [bgd_pkg::QAW:0]   count;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + (bgd_pkg::QAW)'(1);
      if (pop)  rptr <= rptr + (bgd_pkg::QAW)'(1);
      case ({push, pop})
        2'b10:   count <= count + (bgd_pkg::QAW+1)'(1);
        2'b01:   count <= count - (bgd_pkg::QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign rdata      = mem[rptr];
  assign stat.full  = (count == (bgd_pkg::QAW+1)'(bgd_pkg::QDEPTH));
  assign stat.empty = (count == '0);

endmodule

// ----- rtl/bgd_back.sv -----
// Back end: drains queued events and delivers their results one transfer at a time.
module bgd_back (
  input  logic              clk,
  input  logic              rst,
  input  bgd_pkg::ev_t      q_rd,
  input  bgd_pkg::q_stat_t  q_stat,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output bgd_pkg::out_t     out_data
);

  bgd_pkg::ev_t cur;
  logic         cur_valid;
  logic         phase;
  logic         xfer;
  logic         fin;
  logic         take;

  assign xfer  = cur_valid && out_ready;
  assign fin   = xfer && (phase || !cur.two);
  assign take  = !cur_valid || fin;
  assign q_pop = take && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      phase     <= 1'b0;
    end else if (take) begin
      cur_valid <= !q_stat.empty;
      phase     <= 1'b0;
    end else if (xfer) begin
      phase     <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= q_rd;
    end
  end

  assign out_valid = cur_valid;
  assign out_data  = phase ? cur.r1 : cur.r0;

endmodule
